### hw/rtl/lcs_pkg.sv
// Shared constants, types and helpers for the longest common subsequence block.
`default_nettype none

package lcs_pkg;

  // Capacity of the first-string store.
  localparam int MAX_LEN   = 64;
  localparam int ROW_DEPTH = MAX_LEN + 1;
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int STR_AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  // Field widths of the beats.
  localparam int FUNC_W    = 2;
  localparam int CH_W      = 8;
  localparam int OUT_LEN_W = 7;
  localparam int LEN_SAT   = 127;

  // Function codes of an input beat.
  localparam logic [FUNC_W-1:0] FN_LOAD   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FEED   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_FINISH = 2'd2;

  // Request bundle from the sequencer to the row store.
  typedef struct packed {
    logic             rd_en;
    logic [LEN_W-1:0] rd_addr;
    logic             wr_en;
    logic [LEN_W-1:0] wr_addr;
    logic [LEN_W-1:0] wr_data;
    logic             clear;
  } row_req_t;

  // Clamp a row value to the width of the result field.
  function automatic logic [OUT_LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v);
    logic [LEN_W+OUT_LEN_W-1:0] wide;
    wide = {{OUT_LEN_W{1'b0}}, v};
    if (wide > (LEN_W+OUT_LEN_W)'(LEN_SAT)) begin
      return OUT_LEN_W'(LEN_SAT);
    end
    return wide[OUT_LEN_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/longest_common_subsequence_top.sv
// Top level of the longest common subsequence block: sequencer and result register.
//
// Usage:
//   The input channel carries beats of in_func and in_ch. A load beat
//   (FN_LOAD) appends in_ch to the first string; bytes beyond 64 are
//   dropped and the truncation flag is set. A feed beat (FN_FEED) walks
//   the DP row once with in_ch. A finish beat (FN_FINISH) emits one
//   result beat with out_lcs_length and out_truncated, then clears the
//   string, the row and the flag. Code 3 is ignored.
//   Operation: a load never stalls the input. A feed walks row entries 1
//   to L, where L is the number of loaded bytes, in the single update
//   unit, which handles one row entry a cycle through the row
//   memory's one read and one write port. A finish reads the last row
//   entry, then in ST_FIN loads the result register once it is free.
//   in_stall is high while a feed or finish is in progress.
//   Reset (synchronous, rst_n low) empties the string, zeroes the row
//   through its valid bits at once and drops any pending result.
//   While the receiver stalls, the result register holds; a finish then
//   waits in place until the register is free, and the input stays
//   stalled for that whole time.
`default_nettype none

module longest_common_subsequence_top
  import lcs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [FUNC_W-1:0]    in_func,
  input  wire logic [CH_W-1:0]      in_ch,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [OUT_LEN_W-1:0] out_lcs_length,
  output logic                      out_truncated
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             ovf_r, ovf_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic [LEN_W-1:0] left_r, left_nxt;
  logic [LEN_W-1:0] diag_r, diag_nxt;
  logic [CH_W-1:0]  ch_r, ch_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_LEN_W-1:0] out_len_r, out_len_nxt;
  logic                 out_trunc_r, out_trunc_nxt;

  logic              in_acc;
  logic              out_free;
  row_req_t          row_req;
  logic [LEN_W-1:0]  row_q;
  logic              str_wr_en;
  logic [STR_AW-1:0] str_wr_addr;
  logic              str_rd_en;
  logic [STR_AW-1:0] str_rd_addr;
  logic [CH_W-1:0]   str_q;
  logic [LEN_W-1:0]  cell_nxt;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // First-string store.
  lcs_ram #(
    .DEPTH (MAX_LEN),
    .WIDTH (CH_W),
    .AW    (STR_AW)
  ) u_str (
    .clk     (clk),
    .wr_en   (str_wr_en),
    .wr_addr (str_wr_addr),
    .wr_data (in_ch),
    .rd_en   (str_rd_en),
    .rd_addr (str_rd_addr),
    .rd_data (str_q)
  );

  // DP row store.
  lcs_row_store u_row (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (row_req),
    .rd_data (row_q)
  );

  // Shared update unit.
  lcs_cell u_cell (
    .str_byte (str_q),
    .ch       (ch_r),
    .left     (left_r),
    .old      (row_q),
    .diag     (diag_r),
    .nxt      (cell_nxt)
  );

  // Sequencer: next state, memory requests and result register.
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    idx_nxt       = idx_r;
    left_nxt      = left_r;
    diag_nxt      = diag_r;
    ch_nxt        = ch_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_len_nxt   = out_len_r;
    out_trunc_nxt = out_trunc_r;
    row_req       = '0;
    str_wr_en     = 1'b0;
    str_wr_addr   = STR_AW'(len_r);
    str_rd_en     = 1'b0;
    str_rd_addr   = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_func)
            FN_LOAD: begin
              if (len_r < LEN_W'(MAX_LEN)) begin
                str_wr_en = 1'b1;
                len_nxt   = len_r + LEN_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            FN_FEED: begin
              // Start the walk at entry 1; entry 0 is always zero.
              if (len_r != '0) begin
                row_req.rd_en   = 1'b1;
                row_req.rd_addr = LEN_W'(1);
                str_rd_en       = 1'b1;
                str_rd_addr     = '0;
                idx_nxt         = LEN_W'(1);
                left_nxt        = '0;
                diag_nxt        = '0;
                ch_nxt          = in_ch;
                state_nxt       = ST_FEED;
              end
            end
            FN_FINISH: begin
              row_req.rd_en   = 1'b1;
              row_req.rd_addr = len_r;
              state_nxt       = ST_FIN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FEED: begin
        // Write entry idx and fetch entry idx + 1 in the same cycle.
        row_req.wr_en   = 1'b1;
        row_req.wr_addr = idx_r;
        row_req.wr_data = cell_nxt;
        left_nxt        = cell_nxt;
        diag_nxt        = row_q;
        if (idx_r == len_r) begin
          state_nxt = ST_IDLE;
        end else begin
          row_req.rd_en   = 1'b1;
          row_req.rd_addr = idx_r + LEN_W'(1);
          str_rd_en       = 1'b1;
          str_rd_addr     = STR_AW'(idx_r);
          idx_nxt         = idx_r + LEN_W'(1);
        end
      end
      ST_FIN: begin
        // Emit once the result register is free, then clear the state.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = sat_len(row_q);
          out_trunc_nxt = ovf_r;
          row_req.clear = 1'b1;
          len_nxt       = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, counters and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r       <= idx_nxt;
    left_r      <= left_nxt;
    diag_r      <= diag_nxt;
    ch_r        <= ch_nxt;
    out_len_r   <= out_len_nxt;
    out_trunc_r <= out_trunc_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_lcs_length = out_len_r;
  assign out_truncated  = out_trunc_r;

`ifndef SYNTH
  // The string length never exceeds the store.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(MAX_LEN))
    else $error("string length beyond store capacity");

  // The row walk stays inside the loaded prefix.
  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FEED) |-> (idx_r >= LEN_W'(1) && idx_r <= len_r))
    else $error("row walk index out of range");

  // A finish that emits leaves a result and an empty string behind.
  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_free) |=> (out_valid_r && len_r == '0 && !ovf_r))
    else $error("finish did not emit and clear");

  // The row is written only during a walk.
  a_row_write: assert property (@(posedge clk) disable iff (!rst_n)
    row_req.wr_en |-> (state_r == ST_FEED))
    else $error("row write outside a walk");
`endif

endmodule

`default_nettype wire

### hw/rtl/lcs_ram.sv
// Generic single-write, single-read memory with registered read data.
`default_nettype none

module lcs_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds until the next enabled read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lcs_row_store.sv
// Storage for one row of the DP table, with per-entry valid bits for fast clearing.
`default_nettype none

module lcs_row_store
  import lcs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire row_req_t         req,
  output logic      [LEN_W-1:0] rd_data
);

  logic [ROW_DEPTH-1:0] valid_r;
  logic                 rd_valid_r;
  logic [LEN_W-1:0]     ram_q;

  lcs_ram #(
    .DEPTH (ROW_DEPTH),
    .WIDTH (LEN_W),
    .AW    (LEN_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .wr_addr (req.wr_addr),
    .wr_data (req.wr_data),
    .rd_en   (req.rd_en),
    .rd_addr (req.rd_addr),
    .rd_data (ram_q)
  );

  // Valid bits: an entry never written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n || req.clear) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
  end

  // Valid flag travels with the registered read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else if (req.rd_en) begin
      rd_valid_r <= valid_r[req.rd_addr];
    end
  end

  assign rd_data = rd_valid_r ? ram_q : '0;

endmodule

`default_nettype wire

### hw/rtl/lcs_cell.sv
// DP update unit: computes one new row entry from its neighbors.
`default_nettype none

module lcs_cell
  import lcs_pkg::*;
(
  input  wire logic [CH_W-1:0]  str_byte,
  input  wire logic [CH_W-1:0]  ch,
  input  wire logic [LEN_W-1:0] left,
  input  wire logic [LEN_W-1:0] old,
  input  wire logic [LEN_W-1:0] diag,
  output logic      [LEN_W-1:0] nxt
);

  logic [LEN_W-1:0] max_lo;
  logic [LEN_W-1:0] max_all;

  // Maximum of the new left entry, the old entry and the old diagonal.
  assign max_lo  = (left > old) ? left : old;
  assign max_all = (max_lo > diag) ? max_lo : diag;

  // A match extends the diagonal by one.
  assign nxt = (str_byte == ch) ? (diag + LEN_W'(1)) : max_all;

endmodule

`default_nettype wire

### bench/lcs_length_checker.sv
// Checker that predicts each LCS result from the input beats and compares it with the block's output.
`timescale 1ns / 1ps

module lcs_length_checker
  import lcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [CH_W-1:0]      in_ch,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [OUT_LEN_W-1:0] out_lcs_length,
  input  logic                 out_truncated,
  output int                   mismatch_count,
  output int                   pending_count,
  output int                   results_checked
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [OUT_LEN_W-1:0] length;
    logic                 truncated;
  } lcs_result_t;

  // Predicted state: the first string, its DP row and the overflow flag.
  logic [CH_W-1:0]  first_bytes [MAX_LEN];
  int unsigned      first_count = 0;
  logic [LEN_W-1:0] lcs_row [ROW_DEPTH];
  logic             bytes_dropped = 1'b0;

  lcs_result_t expected_results [$];
  int          errors = 0;
  int          checked = 0;

  task automatic clear_prediction();
    int i;
    for (i = 0; i < ROW_DEPTH; i++) begin
      lcs_row[i] = '0;
    end
    first_count   = 0;
    bytes_dropped = 1'b0;
  endtask

  // One second-string byte rewrites the row in place, left to right.
  task automatic advance_row(input logic [CH_W-1:0] c);
    logic [LEN_W-1:0] diag;
    logic [LEN_W-1:0] old;
    logic [LEN_W-1:0] best;
    int               i;
    diag = lcs_row[0];
    for (i = 1; i <= first_count; i++) begin
      old = lcs_row[i];
      if (first_bytes[i-1] == c) begin
        lcs_row[i] = diag + 1'b1;
      end else begin
        best = lcs_row[i-1];
        if (old > best) begin
          best = old;
        end
        if (diag > best) begin
          best = diag;
        end
        lcs_row[i] = best;
      end
      diag = old;
    end
  endtask

  task automatic predict_beat(input logic [FUNC_W-1:0] f, input logic [CH_W-1:0] c);
    lcs_result_t r;
    int unsigned v;
    case (f)
      FN_LOAD: begin
        // A full store drops the byte and remembers that it did.
        if (first_count < MAX_LEN) begin
          first_bytes[first_count] = c;
          first_count++;
        end else begin
          bytes_dropped = 1'b1;
        end
      end
      FN_FEED: begin
        advance_row(c);
      end
      FN_FINISH: begin
        v = lcs_row[first_count];
        if (v > LEN_SAT) begin
          v = LEN_SAT;
        end
        r.length    = OUT_LEN_W'(v);
        r.truncated = bytes_dropped;
        expected_results.push_back(r);
        clear_prediction();
      end
      default: begin
        // The unused code leaves everything as it is.
      end
    endcase
  endtask

  task automatic check_result();
    lcs_result_t e;
    checked++;
    if (expected_results.size() == 0) begin
      errors++;
      if (errors <= REPORT_LIMIT) begin
        $display("Unexpected result beat: length %0d truncated %0b",
                 out_lcs_length, out_truncated);
      end
    end else begin
      e = expected_results.pop_front();
      if (out_lcs_length !== e.length || out_truncated !== e.truncated) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("Mismatch on result %0d: expected length %0d truncated %0b, got %0d %0b",
                   checked, e.length, e.truncated, out_lcs_length, out_truncated);
        end
      end
    end
  endtask

  // Results are compared before the input beat of the same cycle is applied,
  // so a stray result never meets an expectation made in that very cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_prediction();
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        check_result();
      end
      if (in_valid && !in_stall) begin
        predict_beat(in_func, in_ch);
      end
    end
    mismatch_count  <= errors;
    pending_count   <= expected_results.size();
    results_checked <= checked;
  end

endmodule

### bench/longest_common_subsequence_top_test.sv
// Testbench top: clock, reset, stimulus and verdict for the longest common subsequence block.
`timescale 1ns / 1ps

module longest_common_subsequence_top_test;
  import lcs_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  localparam int RESET_CYCLES    = 7;
  localparam int BEATS_PER_PHASE = 250;
  localparam int HOLDOFF_CYCLES  = 300;
  localparam int DRAIN_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT  = 4000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [FUNC_W-1:0]    in_func;
  logic [CH_W-1:0]      in_ch;
  logic                 out_valid;
  logic                 out_stall;
  logic [OUT_LEN_W-1:0] out_lcs_length;
  logic                 out_truncated;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit holdoff_req    = 1'b0;
  int holdoff_left;

  int beats_sent     = 0;
  int finishes_sent  = 0;
  int unused_sent    = 0;
  int overflow_runs  = 0;
  int longest_string = 0;
  int quiet_cycles   = 0;

  int mismatch_count;
  int pending_count;
  int results_checked;

  always #5 clk = ~clk;

  longest_common_subsequence_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_ch          (in_ch),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_lcs_length (out_lcs_length),
    .out_truncated  (out_truncated)
  );

  lcs_length_checker length_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_ch           (in_ch),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_lcs_length  (out_lcs_length),
    .out_truncated   (out_truncated),
    .mismatch_count  (mismatch_count),
    .pending_count   (pending_count),
    .results_checked (results_checked)
  );

  // Receiver: random stalls, or one long hold-off when the stimulus asks for it.
  initial begin
    out_stall    = 1'b0;
    holdoff_left = 0;
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        holdoff_req  = 1'b0;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        out_stall <= 1'b1;
        holdoff_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: ends the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Offers one input beat, after a random gap, and holds it until it is taken.
  task automatic drive_beat(input logic [FUNC_W-1:0] f, input logic [CH_W-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= f;
    in_ch    <= c;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    beats_sent++;
    if (f == FN_FINISH) begin
      finishes_sent++;
    end
    if (f == FN_UNUSED) begin
      unused_sent++;
    end
  endtask

  // A narrow alphabet makes matches common; the full range exercises every bit.
  function automatic logic [CH_W-1:0] random_char(input bit narrow, input logic [CH_W-1:0] base);
    if (narrow) begin
      return base + CH_W'($urandom_range(3));
    end
    return CH_W'($urandom_range(255));
  endfunction

  // One string pair: loads, feeds (sometimes interleaved), then usually a finish.
  task automatic run_string_pair(input bit force_overflow);
    logic [CH_W-1:0] loads [$];
    logic [CH_W-1:0] feeds [$];
    logic [CH_W-1:0] base;
    bit              narrow;
    bit              interleave;
    int              n_load;
    int              n_feed;
    int              pick;
    int              i;
    base   = CH_W'($urandom_range(255));
    narrow = ($urandom_range(99) < 70);
    pick   = $urandom_range(99);
    if (force_overflow) begin
      n_load = MAX_LEN + 1 + $urandom_range(5);
    end else if (pick < 5) begin
      n_load = MAX_LEN + $urandom_range(4);
    end else if (pick < 15) begin
      n_load = 11 + $urandom_range(MAX_LEN - 12);
    end else begin
      n_load = $urandom_range(10);
    end
    for (i = 0; i < n_load; i++) begin
      loads.push_back(random_char(narrow, base));
    end
    if (n_load > longest_string) begin
      longest_string = n_load;
    end
    if (n_load > MAX_LEN) begin
      overflow_runs++;
    end

    // Feeding a mutated copy of the first string drives the length up high.
    if ($urandom_range(99) < 25) begin
      for (i = 0; i < loads.size() && i < MAX_LEN; i++) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          continue;
        end else if (pick < 20) begin
          feeds.push_back(random_char(narrow, base));
        end else begin
          feeds.push_back(loads[i]);
        end
      end
    end else begin
      n_feed = ($urandom_range(99) < 8) ? 13 + $urandom_range(20) : $urandom_range(12);
      for (i = 0; i < n_feed; i++) begin
        feeds.push_back(random_char(narrow, base));
      end
    end

    interleave = ($urandom_range(99) < 15);
    while (loads.size() != 0 || feeds.size() != 0) begin
      if ($urandom_range(99) < 3) begin
        drive_beat(FN_UNUSED, CH_W'($urandom_range(255)));
      end
      if (loads.size() != 0 && (feeds.size() == 0 || !interleave || $urandom_range(1))) begin
        drive_beat(FN_LOAD, loads.pop_front());
      end else begin
        drive_beat(FN_FEED, feeds.pop_front());
      end
    end
    // Now and then the finish is left out, so the next pair builds on this one.
    if ($urandom_range(99) < 92) begin
      drive_beat(FN_FINISH, CH_W'($urandom_range(255)));
    end
  endtask

  // One idling mix; its first pair always overruns the store.
  task automatic run_phase(input int send_pct, input int recv_pct);
    int target;
    bit first;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    target         = beats_sent - unused_sent + BEATS_PER_PHASE;
    first          = 1'b1;
    while (beats_sent - unused_sent < target) begin
      run_string_pair(first);
      first = 1'b0;
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_func  = FN_LOAD;
    in_ch    = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Both strings empty.
    drive_beat(FN_FINISH, 8'h00);
    // Extreme byte values, with an ignored code in the middle of the feeds.
    drive_beat(FN_LOAD, 8'h00);
    drive_beat(FN_LOAD, 8'hFF);
    drive_beat(FN_LOAD, 8'h5A);
    drive_beat(FN_FEED, 8'hFF);
    drive_beat(FN_UNUSED, 8'hA5);
    drive_beat(FN_FEED, 8'h00);
    drive_beat(FN_FEED, 8'h5A);
    drive_beat(FN_FINISH, 8'hFF);
    // First string only.
    drive_beat(FN_LOAD, 8'h41);
    drive_beat(FN_FINISH, 8'h00);
    // Second string only.
    drive_beat(FN_FEED, 8'h41);
    drive_beat(FN_FINISH, 8'h00);
    // A byte loaded after feeding starts from a zero row entry.
    drive_beat(FN_LOAD, 8'h11);
    drive_beat(FN_FEED, 8'h22);
    drive_beat(FN_LOAD, 8'h22);
    drive_beat(FN_FEED, 8'h11);
    drive_beat(FN_FEED, 8'h22);
    drive_beat(FN_FINISH, 8'h00);

    // Long output hold-off while short pairs keep coming, so finishes back up.
    holdoff_req = 1'b1;
    repeat (6) begin
      drive_beat(FN_LOAD, CH_W'($urandom_range(2)));
      drive_beat(FN_LOAD, CH_W'($urandom_range(2)));
      drive_beat(FN_FEED, CH_W'($urandom_range(2)));
      drive_beat(FN_FEED, CH_W'($urandom_range(2)));
      drive_beat(FN_FINISH, CH_W'($urandom_range(255)));
    end

    run_phase(0, 0);
    run_phase(62, 0);
    run_phase(0, 62);
    run_phase(32, 32);
    in_valid <= 1'b0;

    // Drain: every expected result must arrive, then the block must stay quiet.
    @(posedge clk);
    while (pending_count != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Drove %0d beats (%0d finishes, %0d ignored codes) under four idle mixes and a %0d-cycle hold-off.",
             beats_sent, finishes_sent, unused_sent, HOLDOFF_CYCLES);
    $display("Checked %0d results; %0d first strings overran the %0d-byte store, longest %0d bytes.",
             results_checked, overflow_runs, MAX_LEN, longest_string);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
